### rtl/core/pkd_pkg.sv
// ----------------------------------------------------------------------------
// pkd_pkg
// Shared types and constants of the per-key asymmetric deferred debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package pkd_pkg;

  localparam int OUT_W = 16;
  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE    = 2'd2;

  localparam logic [CNT_W-1:0] PRESS_RESET   = 8'd5;
  localparam logic [CNT_W-1:0] RELEASE_RESET = 8'd5;
  localparam logic [CNT_W-1:0] MUTE_RESET    = 8'd20;

  typedef struct packed {
    logic [CNT_W-1:0] press_delay;
    logic [CNT_W-1:0] release_delay;
    logic [CNT_W-1:0] mute_period;
  } pkd_cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] cooked;
    logic [OUT_W-1:0] commit;
    logic             busy;
  } pkd_res_t;

endpackage

`default_nettype wire

### rtl/core/pkd_lane.sv
// ----------------------------------------------------------------------------
// pkd_lane
// Countdown and commit logic of one key.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_lane
  import pkd_pkg::*;
(
  input  pkd_cfg_t         cfg,
  input  logic [CNT_W-1:0] cnt,
  input  logic             raw,
  input  logic             cooked,
  input  logic             changed,
  input  logic [CNT_W-1:0] elapsed,
  output logic [CNT_W-1:0] cnt_nxt,
  output logic             cooked_nxt,
  output logic             commit
);

  logic differs;

  assign differs = raw ^ cooked;

  always_comb begin
    cnt_nxt    = cnt;
    cooked_nxt = cooked;
    commit     = 1'b0;
    if (cnt > elapsed) begin
      cnt_nxt = cnt - elapsed;
    end else if (cnt != '0) begin
      if (differs) begin
        cooked_nxt = ~cooked;
        commit     = 1'b1;
        cnt_nxt    = cfg.mute_period;
      end else begin
        cnt_nxt = '0;
      end
    end else if (changed && differs) begin
      cnt_nxt = raw ? cfg.press_delay : cfg.release_delay;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pkd_merge.sv
// ----------------------------------------------------------------------------
// pkd_merge
// Combines the lane outputs into the result word of one row.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_merge
  import pkd_pkg::*;
#(
  parameter int COLS = 16
) (
  input  logic [COLS*CNT_W-1:0] cnt_nxt,
  input  logic [COLS-1:0]       cooked_nxt,
  input  logic [COLS-1:0]       commit,
  input  logic                  in_range,
  output pkd_res_t              res
);

  logic [OUT_W-1:0] cooked_w;
  logic [OUT_W-1:0] commit_w;
  logic [COLS-1:0]  lane_busy;

  genvar j;
  generate
    for (j = 0; j < OUT_W; j++) begin : g_out
      if (j < COLS) begin : g_have
        assign cooked_w[j] = cooked_nxt[j];
        assign commit_w[j] = commit[j];
      end else begin : g_none
        assign cooked_w[j] = 1'b0;
        assign commit_w[j] = 1'b0;
      end
    end
    for (j = 0; j < COLS; j++) begin : g_busy
      assign lane_busy[j] = cnt_nxt[j*CNT_W +: CNT_W] != '0;
    end
  endgenerate

  assign res.cooked = in_range ? cooked_w : '0;
  assign res.commit = in_range ? commit_w : '0;
  assign res.busy   = in_range && (lane_busy != '0);

endmodule

`default_nettype wire

### rtl/core/pkd_row_store.sv
// ----------------------------------------------------------------------------
// pkd_row_store
// Row-wide memory of countdowns and cooked levels, with row valid bits and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_row_store #(
  parameter int ROWS = 16,
  parameter int W = 144,
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0]    mem [ROWS];
  logic [ROWS-1:0] valid_r;
  logic [W-1:0]    rd_data_r;
  logic            rd_ok_r;
  logic            fwd;

  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= fwd ? wr_data : mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= fwd || valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

`default_nettype wire

### rtl/core/per_key_asym_defer_debounce.sv
// ----------------------------------------------------------------------------
// per_key_asym_defer_debounce
// Per-key asymmetric deferred debouncer, one keyboard-matrix row per word.
//
//   channel  ports                                     direction
//   in       in_valid/in_ready, row, raw, changed, el  scan words in
//   out      out_valid/out_ready, cooked, commit, busy result words out
//   cfg      cfg_wr_en, cfg_index, cfg_wdata           register writes
//
// A word is read from the row memory in the cycle it is accepted, updated by
// one lane per key in the update stage and then registered as the result; a
// word may be accepted every cycle unless the output stalls, and back-to-back
// words of one row are forwarded from the write port. Reset clears the row
// valid bits at once, so no clearing pass is needed. A stalled output holds
// one result and one word in flight before in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module per_key_asym_defer_debounce
  import pkd_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_row_index,
  input  logic [15:0]          in_raw_bits,
  input  logic                 in_scan_changed,
  input  logic [7:0]           in_elapsed_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_cooked_bits,
  output logic [15:0]          out_commit_bits,
  output logic                 out_row_busy,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW = AW + 4;
  localparam int W = COLS * (CNT_W + 1);

  pkd_cfg_t cfg_r;

  logic             s1_v_r;
  logic [AW-1:0]    s1_row_r;
  logic             s1_inr_r;
  logic [15:0]      s1_raw_r;
  logic             s1_chg_r;
  logic [CNT_W-1:0] s1_el_r;

  logic             out_valid_r;
  pkd_res_t         out_res_r;

  logic             accept;
  logic             s1_adv;
  logic [XW-1:0]    row_ext;
  logic             in_range;
  logic [W-1:0]     rd_data;
  logic [W-1:0]     wr_data;
  logic [COLS*CNT_W-1:0] cnt_nxt;
  logic [COLS-1:0]  cooked_nxt;
  logic [COLS-1:0]  commit;
  pkd_res_t         res;

  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign row_ext  = {{AW{1'b0}}, in_row_index};
  assign in_range = row_ext < XW'(ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_delay   <= PRESS_RESET;
      cfg_r.release_delay <= RELEASE_RESET;
      cfg_r.mute_period   <= MUTE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PRESS:   cfg_r.press_delay   <= cfg_wdata;
        CFG_RELEASE: cfg_r.release_delay <= cfg_wdata;
        CFG_MUTE:    cfg_r.mute_period   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r <= row_ext[AW-1:0];
      s1_inr_r <= in_range;
      s1_raw_r <= in_raw_bits;
      s1_chg_r <= in_scan_changed;
      s1_el_r  <= in_elapsed_ticks;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  pkd_row_store #(
    .ROWS (ROWS),
    .W    (W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range),
    .rd_addr (row_ext[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (s1_adv && s1_inr_r),
    .wr_addr (s1_row_r),
    .wr_data (wr_data)
  );

  genvar c;
  generate
    for (c = 0; c < COLS; c++) begin : g_lane
      logic raw_bit;
      if (c < 16) begin : g_raw
        assign raw_bit = s1_raw_r[c];
      end else begin : g_zero
        assign raw_bit = 1'b0;
      end
      pkd_lane u_lane (
        .cfg        (cfg_r),
        .cnt        (rd_data[c*CNT_W +: CNT_W]),
        .raw        (raw_bit),
        .cooked     (rd_data[COLS*CNT_W + c]),
        .changed    (s1_chg_r),
        .elapsed    (s1_el_r),
        .cnt_nxt    (cnt_nxt[c*CNT_W +: CNT_W]),
        .cooked_nxt (cooked_nxt[c]),
        .commit     (commit[c])
      );
    end
  endgenerate

  assign wr_data = {cooked_nxt, cnt_nxt};

  pkd_merge #(
    .COLS (COLS)
  ) u_merge (
    .cnt_nxt    (cnt_nxt),
    .cooked_nxt (cooked_nxt),
    .commit     (commit),
    .in_range   (s1_inr_r),
    .res        (res)
  );

  assign out_valid       = out_valid_r;
  assign out_cooked_bits = out_res_r.cooked;
  assign out_commit_bits = out_res_r.commit;
  assign out_row_busy    = out_res_r.busy;

`ifndef SYNTHESIS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_inr_r |=> out_valid_r && out_res_r.cooked == '0 &&
      out_res_r.commit == '0 && !out_res_r.busy)
    else $error("out-of-range row gave a nonzero result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted word lost before the update stage");

  a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("updated row lost before the output register");
`endif

endmodule

`default_nettype wire

### tb/debounce_tb_pkg.sv
// ----------------------------------------------------------------------------
// debounce_tb_pkg
// Scoreboard for the per-key asymmetric deferred debouncer. It keeps its own
// copy of the key countdowns, the cooked rows and the delay registers, works
// out the result word of every accepted scan word and checks the result words
// of the block against those expectations in order.
// ----------------------------------------------------------------------------
package debounce_tb_pkg;
  import pkd_pkg::*;

  localparam int KEY_ROWS = 16;
  localparam int KEY_COLS = 16;

  class row_debounce_scoreboard;
    bit [CNT_W-1:0] press_delay;
    bit [CNT_W-1:0] release_delay;
    bit [CNT_W-1:0] mute_period;
    bit [CNT_W-1:0] key_countdown [KEY_ROWS][KEY_COLS];
    bit [OUT_W-1:0] cooked_rows [KEY_ROWS];
    pkd_res_t       expected_rows [$];
    int unsigned    errors;

    function new();
      press_delay   = PRESS_RESET;
      release_delay = RELEASE_RESET;
      mute_period   = MUTE_RESET;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_PRESS: begin
          press_delay = val;
        end
        CFG_RELEASE: begin
          release_delay = val;
        end
        CFG_MUTE: begin
          mute_period = val;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_scan(logic [3:0] row, logic [15:0] raw, logic changed,
                            logic [7:0] elapsed);
      pkd_res_t       res;
      bit [15:0]      cooked;
      bit [15:0]      delta;
      bit [CNT_W-1:0] cnt;
      res = '0;
      if (row < KEY_ROWS) begin
        cooked = cooked_rows[row];
        delta  = raw ^ cooked;
        for (int col = 0; col < KEY_COLS; col++) begin
          cnt = key_countdown[row][col];
          if (cnt > elapsed) begin
            cnt = cnt - elapsed;
          end else if (cnt != 0) begin
            if (delta[col]) begin
              cooked[col]     = ~cooked[col];
              res.commit[col] = 1'b1;
              cnt             = mute_period;
            end else begin
              cnt = '0;
            end
          end else if (changed && delta[col]) begin
            cnt = raw[col] ? press_delay : release_delay;
          end
          if (cnt != 0) begin
            res.busy = 1'b1;
          end
          key_countdown[row][col] = cnt;
        end
        cooked_rows[row] = cooked;
        res.cooked       = cooked;
      end
      expected_rows.push_back(res);
    endfunction

    function void check_result(logic [15:0] cooked, logic [15:0] commit, logic busy);
      pkd_res_t exp_res;
      if (expected_rows.size() == 0) begin
        $error("result word with no scan word outstanding: cooked %h commit %h busy %b",
               cooked, commit, busy);
        errors++;
        return;
      end
      exp_res = expected_rows.pop_front();
      if (cooked !== exp_res.cooked) begin
        $error("cooked_bits mismatch: expected %h, actual %h", exp_res.cooked, cooked);
        errors++;
      end
      if (commit !== exp_res.commit) begin
        $error("commit_bits mismatch: expected %h, actual %h", exp_res.commit, commit);
        errors++;
      end
      if (busy !== exp_res.busy) begin
        $error("row_busy mismatch: expected %b, actual %b", exp_res.busy, busy);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_rows.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression of the per-key asymmetric deferred debouncer. A short directed
// sequence walks through press, hold, commit, mute and release, then a series
// of register settings (the extremes, zero delays and zero mute among them) is
// run with keyboard-like scan passes over a model key matrix that bounces,
// mixed with random words, under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pkd_pkg::*;
  import debounce_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [3:0]           in_row_index = '0;
  logic [15:0]          in_raw_bits = '0;
  logic                 in_scan_changed = 1'b0;
  logic [7:0]           in_elapsed_ticks = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          out_cooked_bits;
  logic [15:0]          out_commit_bits;
  logic                 out_row_busy;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  row_debounce_scoreboard sb;
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned cycle_count = 0;
  logic [15:0] key_level [16];

  per_key_asym_defer_debounce u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_row_index     (in_row_index),
    .in_raw_bits      (in_raw_bits),
    .in_scan_changed  (in_scan_changed),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cooked_bits  (out_cooked_bits),
    .out_commit_bits  (out_commit_bits),
    .out_row_busy     (out_row_busy),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver holds off for a counted stretch when asked, else stalls at random.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= dst_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_scan(in_row_index, in_raw_bits, in_scan_changed, in_elapsed_ticks);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_cooked_bits, out_commit_bits, out_row_busy);
    end
  end

  task automatic send_word(input logic [3:0] row, input logic [15:0] raw,
                           input logic chg, input logic [7:0] el);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_row_index     <= row;
    in_raw_bits      <= raw;
    in_scan_changed  <= chg;
    in_elapsed_ticks <= el;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] press, input logic [7:0] rel,
                                input logic [7:0] mute);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [7:0]           val [4];
    idx = '{CFG_PRESS, CFG_RELEASE, CFG_MUTE, CFG_UNUSED};
    val = '{press, rel, mute, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Scan passes over consecutive rows of a bouncing key matrix, with some
  // words of pure noise in between.
  task automatic run_scans(input int unsigned n);
    int unsigned left;
    int unsigned span;
    int unsigned sel;
    logic [3:0]  row;
    logic [7:0]  el;
    logic        chg;
    logic        flipped;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 12) begin
        send_word(4'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
        left--;
      end else begin
        flipped = 1'b0;
        if ($urandom_range(99) < 45) begin
          row            = 4'($urandom);
          key_level[row] = key_level[row] ^ 16'($urandom & $urandom);
          flipped        = 1'b1;
        end
        chg = flipped ? ($urandom_range(99) >= 8) : ($urandom_range(99) < 15);
        sel = $urandom_range(99);
        if (sel < 55) begin
          el = 8'($urandom_range(3));
        end else if (sel < 75) begin
          el = 8'($urandom_range(4, 30));
        end else if (sel < 88) begin
          el = 8'd255;
        end else begin
          el = 8'($urandom);
        end
        row  = 4'($urandom);
        span = $urandom_range(1, 16);
        repeat (span) begin
          send_word(row, key_level[row], chg, el);
          row++;
          if (left > 0) begin
            left--;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] press, input logic [7:0] rel,
                           input logic [7:0] mute, input int unsigned src_pct,
                           input int unsigned dst_pct, input int unsigned hold);
    in_valid <= 1'b0;
    drain_results();
    apply_settings(press, rel, mute);
    src_idle_pct    = src_pct;
    dst_stall_pct   = dst_pct;
    hold_off_cycles = hold;
    run_scans(210);
  endtask

  initial begin
    sb = new();
    for (int r = 0; r < 16; r++) begin
      key_level[r] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(4'd0, 16'hFFFF, 1'b1, 8'd0);
    send_word(4'd0, 16'hFFFF, 1'b0, 8'd0);
    send_word(4'd0, 16'hFFFF, 1'b0, 8'd4);
    send_word(4'd0, 16'hFFFF, 1'b0, 8'd1);
    send_word(4'd0, 16'h0000, 1'b1, 8'd255);
    send_word(4'd0, 16'h0000, 1'b0, 8'd20);
    send_word(4'd15, 16'h8001, 1'b0, 8'd0);
    send_word(4'd15, 16'h8001, 1'b1, 8'd255);
    send_word(4'd15, 16'h8000, 1'b0, 8'd5);
    send_word(4'd15, 16'h0000, 1'b1, 8'd3);
    send_word(4'd15, 16'h0000, 1'b1, 8'd255);
    send_word(4'd7, 16'hA5A5, 1'b1, 8'd0);
    send_word(4'd7, 16'h5A5A, 1'b1, 8'd2);
    send_word(4'd7, 16'h5A5A, 1'b0, 8'd255);
    send_word(4'd3, 16'hFFFF, 1'b1, 8'd255);
    send_word(4'd3, 16'hFFFF, 1'b1, 8'd128);
    send_word(4'd8, 16'h0000, 1'b0, 8'd0);
    send_word(4'd8, 16'hFFFF, 1'b1, 8'd1);

    run_phase(8'd1, 8'd1, 8'd1, 0, 0, 0);
    run_phase(8'd255, 8'd255, 8'd255, 52, 0, 0);
    run_phase(8'd0, 8'd0, 8'd0, 0, 52, 0);
    run_phase(8'd2, 8'd12, 8'd0, 23, 23, 0);
    run_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
              8'($urandom_range(1, 30)), 0, 0, 300);
    run_phase(8'd12, 8'd2, 8'd255, 52, 0, 0);
    run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
              8'($urandom_range(0, 40)), 0, 52, 0);
    run_phase(8'd5, 8'd5, 8'd20, 23, 23, 0);

    in_valid <= 1'b0;
    drain_results();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
